[rtl/core/tukey_window_coefficient_macros.svh]
// Assertion macros shared by the Tukey window coefficient RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TUKEY_WINDOW_COEFFICIENT_MACROS_SVH
`define TUKEY_WINDOW_COEFFICIENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tukey window coefficient: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TKW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tukey window coefficient: next-cycle check failed");

`endif

[rtl/core/tkw_pkg.sv]
// Package for the Tukey window coefficient generator: widths, register indices,
// CORDIC constants and the tag carried with every request. No dependencies.
`timescale 1ns / 1ps

package tkw_pkg;

   localparam int MAX_LENGTH     = 4096;
   localparam int COEF_FRAC_BITS = 16;

   localparam int LEN_W     = 13;
   localparam int IDX_W     = 12;
   localparam int ALPHA_W   = 17;
   localparam int CENTRE_W  = 14;
   localparam int POS_W     = 16;
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 3;
   localparam int T2_W      = ALPHA_W + LEN_W;
   localparam int FRAC_SH   = 17;
   localparam int QUO_W     = 31;
   localparam int ANG_W     = 32;
   localparam int CORDIC_W  = 34;
   localparam int CORDIC_STEPS = 16;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

   localparam logic [ANG_W-1:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [ANG_W-1:0] PI_Q30      = 32'd3373259426;
   localparam logic [ANG_W-1:0] GAIN_Q30    = 32'd652032874;
   localparam logic [ANG_W-1:0] ONE_Q30     = 32'd1073741824;

   localparam logic [ANG_W-1:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
      32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
      32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
      32'd262143,    32'd131071,    32'd65535,     32'd32767
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOTAL_LENGTH    = 3'd0,
      CSR_WINDOW_LENGTH   = 3'd1,
      CSR_TAPER_FRACTION  = 3'd2,
      CSR_CENTERING_ON    = 3'd3,
      CSR_CENTRE_POSITION = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic in_window;
      logic taper;
   } tag_type;

endpackage

[rtl/core/tkw_front.sv]
// Window geometry stages: placement, taper length and edge distance of each request.
// Depends on tkw_pkg.
`timescale 1ns / 1ps

module tkw_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [tkw_pkg::IDX_W-1:0]           sample_index,
   input  logic [tkw_pkg::LEN_W-1:0]           total_length,
   input  logic [tkw_pkg::LEN_W-1:0]           window_length,
   input  logic [tkw_pkg::ALPHA_W-1:0]         taper_fraction,
   input  logic                                centering_on,
   input  logic [tkw_pkg::CENTRE_W-1:0]        centre_position,
   output tkw_pkg::tag_type                    out_tag,
   output logic [tkw_pkg::LEN_W-1:0]           out_m,
   output logic [tkw_pkg::T2_W-1:0]            out_t2
);

   localparam int LW = tkw_pkg::LEN_W;
   localparam int PW = tkw_pkg::POS_W;
   localparam int TW = tkw_pkg::T2_W;
   localparam int FS = tkw_pkg::FRAC_SH;

   logic [LW-1:0]               len_c;
   logic [LW-1:0]               win_c;
   logic [tkw_pkg::ALPHA_W-1:0] alpha_c;
   logic [PW-1:0]               shift_c;
   logic [PW-1:0]               j_c;
   logic                        inside_c;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_inside_ff;
   logic [LW-1:0]               s1_j_ff;
   logic [LW-1:0]               s1_win_ff;
   logic [tkw_pkg::ALPHA_W-1:0] s1_alpha_ff;

   logic                        s2_valid_ff;
   logic                        s2_inside_ff;
   logic [LW-1:0]               s2_j_ff;
   logic [LW-1:0]               s2_win_ff;
   logic [TW-1:0]               s2_t2_ff, s2_t2_in;

   logic [LW-1:0]               lo_c, hi_c, m_c;
   logic [TW-1:0]               hi_full_c;
   logic                        edge_hi_c, edge_lo_c;

   tkw_pkg::tag_type            s3_tag_ff, s3_tag_in;
   logic [LW-1:0]               s3_m_ff;
   logic [TW-1:0]               s3_t2_ff;

   always_comb begin
      if (total_length == '0) begin
         len_c = LW'(1);
      end else if ({4'b0, total_length} > 17'(tkw_pkg::MAX_LENGTH)) begin
         len_c = LW'(tkw_pkg::MAX_LENGTH);
      end else begin
         len_c = total_length;
      end
      if (window_length == '0) begin
         win_c = len_c;
      end else if ({4'b0, window_length} > 17'(tkw_pkg::MAX_LENGTH)) begin
         win_c = LW'(tkw_pkg::MAX_LENGTH);
      end else begin
         win_c = window_length;
      end
      alpha_c = (taper_fraction > tkw_pkg::ALPHA_ONE) ? tkw_pkg::ALPHA_ONE : taper_fraction;
      if (centering_on) begin
         shift_c = {{(PW - tkw_pkg::CENTRE_W){centre_position[tkw_pkg::CENTRE_W-1]}},
                    centre_position} - {{(PW - LW + 1){1'b0}}, win_c[LW-1:1]};
      end else begin
         shift_c = '0;
      end
      j_c = {{(PW - tkw_pkg::IDX_W){1'b0}}, sample_index} - shift_c;
      inside_c = ({1'b0, sample_index} < len_c) && !j_c[PW-1]
                 && (j_c < {{(PW - LW){1'b0}}, win_c});
   end

   assign s1_valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_tag_ff   <= '0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_tag_ff   <= s3_tag_in;
      end
   end

   assign s2_t2_in = s1_alpha_ff * (s1_win_ff - LW'(1));

   always_comb begin
      lo_c      = s2_t2_ff[TW-1:FS];
      hi_full_c = {s2_win_ff, {FS{1'b0}}} - s2_t2_ff;
      hi_c      = hi_full_c[TW-1:FS];
      edge_hi_c = s2_j_ff >= hi_c;
      edge_lo_c = s2_j_ff < lo_c;
      m_c       = edge_hi_c ? (s2_win_ff - LW'(1) - s2_j_ff) : s2_j_ff;
      s3_tag_in.valid     = s2_valid_ff;
      s3_tag_in.in_window = s2_inside_ff;
      s3_tag_in.taper     = s2_inside_ff && (edge_hi_c || edge_lo_c);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_inside_ff <= inside_c;
         s1_j_ff      <= j_c[LW-1:0];
         s1_win_ff    <= win_c;
         s1_alpha_ff  <= alpha_c;
         s2_inside_ff <= s1_inside_ff;
         s2_j_ff      <= s1_j_ff;
         s2_win_ff    <= s1_win_ff;
         s2_t2_ff     <= s2_t2_in;
         s3_m_ff      <= m_c;
         s3_t2_ff     <= s2_t2_ff;
      end
   end

   assign out_tag = s3_tag_ff;
   assign out_m   = s3_m_ff;
   assign out_t2  = s3_t2_ff;

endmodule

[rtl/core/tkw_divider.sv]
// Pipelined restoring divider giving the taper phase, one quotient bit per stage.
// Depends on tkw_pkg.
`timescale 1ns / 1ps

module tkw_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  tkw_pkg::tag_type              in_tag,
   input  logic [tkw_pkg::LEN_W-1:0]     in_m,
   input  logic [tkw_pkg::T2_W-1:0]      in_t2,
   output tkw_pkg::tag_type              out_tag,
   output logic [tkw_pkg::QUO_W-1:0]     out_phase
);

   localparam int TW = tkw_pkg::T2_W;
   localparam int QW = tkw_pkg::QUO_W;

   logic [TW-1:0]    num_c;
   logic             sat_c;

   tkw_pkg::tag_type tag_ff [0:QW];
   logic             sat_ff [0:QW];
   logic [QW-1:0]    quo_ff [0:QW];
   logic [TW-1:0]    rem_ff [0:QW-1];
   logic [TW-1:0]    t2_ff  [0:QW-1];

   assign num_c = {in_m, {tkw_pkg::FRAC_SH{1'b0}}};
   assign sat_c = num_c >= in_t2;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (advance) begin
         tag_ff[0] <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sat_ff[0] <= sat_c;
         quo_ff[0] <= '0;
         rem_ff[0] <= sat_c ? '0 : num_c;
         t2_ff[0]  <= in_t2;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [TW:0]   r2_c;
      logic          ge_c;
      logic [TW:0]   diff_c;
      logic [TW-1:0] rem_in;

      assign r2_c   = {rem_ff[k], 1'b0};
      assign ge_c   = r2_c >= {1'b0, t2_ff[k]};
      assign diff_c = r2_c - {1'b0, t2_ff[k]};
      assign rem_in = ge_c ? diff_c[TW-1:0] : r2_c[TW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k+1] <= '0;
         end else if (advance) begin
            tag_ff[k+1] <= tag_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sat_ff[k+1] <= sat_ff[k];
            quo_ff[k+1] <= {quo_ff[k][QW-2:0], ge_c};
         end
      end

      if (k < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k+1] <= rem_in;
               t2_ff[k+1]  <= t2_ff[k];
            end
         end
      end
   end

   assign out_tag   = tag_ff[QW];
   assign out_phase = sat_ff[QW] ? '1 : quo_ff[QW];

endmodule

[rtl/core/tkw_cordic.sv]
// Angle multiply, quadrant fold, pipelined CORDIC cosine and Q1.F coefficient rounding.
// Depends on tkw_pkg.
`timescale 1ns / 1ps

module tkw_cordic #(
   parameter int COEF_FRAC_BITS = tkw_pkg::COEF_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  tkw_pkg::tag_type            in_tag,
   input  logic [tkw_pkg::QUO_W-1:0]   in_phase,
   output tkw_pkg::tag_type            out_tag,
   output logic [COEF_FRAC_BITS:0]     out_coefficient
);

   localparam int CW = tkw_pkg::CORDIC_W;
   localparam int AW = tkw_pkg::ANG_W;
   localparam int NS = tkw_pkg::CORDIC_STEPS;
   localparam int PRW = tkw_pkg::QUO_W + AW;

   logic [PRW-1:0]          prod_c;
   tkw_pkg::tag_type        mul_tag_ff;
   logic [AW-1:0]           mul_theta_ff;

   logic                    fold_c;
   logic [AW-1:0]           angle_c;

   tkw_pkg::tag_type        tag_ff [0:NS];
   logic                    neg_ff [0:NS];
   logic signed [CW-1:0]    x_ff   [0:NS];
   logic signed [CW-1:0]    y_ff   [0:NS-1];
   logic signed [CW-1:0]    z_ff   [0:NS-1];

   logic signed [CW-1:0]    one_c;
   logic signed [CW-1:0]    xc_c;
   logic signed [CW-1:0]    cos_c;
   logic [CW-1:0]           diff_c;
   logic [CW-1:0]           q_c;
   logic [CW-1:0]           sum_c;
   logic [CW-1:0]           r_c;
   logic [COEF_FRAC_BITS:0] coef_in, coef_ff;
   tkw_pkg::tag_type        fin_tag_ff;

   assign prod_c = in_phase * tkw_pkg::PI_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_tag_ff <= '0;
         tag_ff[0]  <= '0;
         fin_tag_ff <= '0;
      end else if (advance) begin
         mul_tag_ff <= in_tag;
         tag_ff[0]  <= mul_tag_ff;
         fin_tag_ff <= tag_ff[NS];
      end
   end

   assign fold_c  = mul_theta_ff > tkw_pkg::HALF_PI_Q30;
   assign angle_c = fold_c ? (tkw_pkg::PI_Q30 - mul_theta_ff) : mul_theta_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_theta_ff <= prod_c[PRW-1:tkw_pkg::QUO_W];
         neg_ff[0]    <= fold_c;
         x_ff[0]      <= $signed({{(CW - AW){1'b0}}, tkw_pkg::GAIN_Q30});
         y_ff[0]      <= '0;
         z_ff[0]      <= $signed({{(CW - AW){1'b0}}, angle_c});
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_rot
      logic signed [CW-1:0] atan_c;
      logic signed [CW-1:0] x_in, y_in, z_in;

      assign atan_c = $signed({{(CW - AW){1'b0}}, tkw_pkg::ATAN_Q30[k]});

      always_comb begin
         if (!z_ff[k][CW-1]) begin
            x_in = x_ff[k] - (y_ff[k] >>> k);
            y_in = y_ff[k] + (x_ff[k] >>> k);
            z_in = z_ff[k] - atan_c;
         end else begin
            x_in = x_ff[k] + (y_ff[k] >>> k);
            y_in = y_ff[k] - (x_ff[k] >>> k);
            z_in = z_ff[k] + atan_c;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k+1] <= '0;
         end else if (advance) begin
            tag_ff[k+1] <= tag_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[k+1]   <= x_in;
            neg_ff[k+1] <= neg_ff[k];
         end
      end

      if (k < NS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               y_ff[k+1] <= y_in;
               z_ff[k+1] <= z_in;
            end
         end
      end
   end

   always_comb begin
      one_c = $signed({{(CW - AW){1'b0}}, tkw_pkg::ONE_Q30});
      if (x_ff[NS] > one_c) begin
         xc_c = one_c;
      end else if (x_ff[NS] < -one_c) begin
         xc_c = -one_c;
      end else begin
         xc_c = x_ff[NS];
      end
      cos_c  = neg_ff[NS] ? -xc_c : xc_c;
      diff_c = one_c - cos_c;
      q_c    = diff_c >> 1;
      sum_c  = q_c + (CW'(1) << (29 - COEF_FRAC_BITS));
      r_c    = sum_c >> (30 - COEF_FRAC_BITS);
      if (r_c > (CW'(1) << COEF_FRAC_BITS)) begin
         r_c = CW'(1) << COEF_FRAC_BITS;
      end
      if (tag_ff[NS].taper) begin
         coef_in = r_c[COEF_FRAC_BITS:0];
      end else if (tag_ff[NS].in_window) begin
         coef_in = (COEF_FRAC_BITS+1)'(1) << COEF_FRAC_BITS;
      end else begin
         coef_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         coef_ff <= coef_in;
      end
   end

   assign out_tag         = fin_tag_ff;
   assign out_coefficient = coef_ff;

endmodule

[rtl/core/tkw_out_buf.sv]
// Two-entry result buffer between the pipeline and the response channel.
// Depends on tkw_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "tukey_window_coefficient_macros.svh"

module tkw_out_buf #(
   parameter int DATA_W = tkw_pkg::COEF_FRAC_BITS + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DATA_W-1:0] in_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_data
);

   logic [DATA_W-1:0] slot_ff [0:1];
   logic [1:0]        count_ff, count_in;
   logic              rd_ff, rd_in;
   logic              wr_ff, wr_in;
   logic              push, pop;

   assign full      = count_ff == 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign push      = in_valid && !full;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

   `TKW_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)
   `TKW_ASSERT_SAME(a_pointer_gap, clock, reset, count_ff == 2'd1, rd_ff != wr_ff)
   `TKW_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push, count_ff == $past(count_ff) - 2'd1)
   `TKW_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

[rtl/core/tukey_window_coefficient.sv]
// Tukey window coefficient generator, top level.
// Requests on req_* carry a sample index; responses on rsp_* carry the Q1.F coefficient
// and a flag saying whether the index lies inside the placed window.
// Both channels use valid/ready; a transfer happens when valid and ready are high together.
// Registers are written through csr_write_enable, csr_index and csr_write_data with no wait,
// and are to be changed only while no request is in flight.
// Throughput is one request per cycle while the result buffer is not full. An accepted
// request passes through three geometry stages, 32 divider stages (a saturation check, then
// one quotient bit each), the angle multiplier, the quadrant fold, 16 CORDIC stages and the
// rounding stage, and its response then waits in the buffer until the receiver is ready.
// A two-entry buffer holds finished responses; req_ready is low only while it is full, and
// the whole pipeline then holds without losing or repeating any request.
// Synchronous active-high reset empties the pipeline and the buffer and loads the register
// defaults: frame length 1024, window length zero (full frame), taper one half, centring off,
// centre position 512.
// Depends on tkw_pkg, tkw_front, tkw_divider, tkw_cordic and tkw_out_buf.
`timescale 1ns / 1ps

module tukey_window_coefficient #(
   parameter int COEF_FRAC_BITS = tkw_pkg::COEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tkw_pkg::IDX_W-1:0]         req_sample_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [COEF_FRAC_BITS:0]           rsp_coefficient,
   output logic                              rsp_inside_window,
   input  logic                              csr_write_enable,
   input  logic [tkw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tkw_pkg::CSR_W-1:0]         csr_write_data
);

   logic [tkw_pkg::LEN_W-1:0]    total_length_ff;
   logic [tkw_pkg::LEN_W-1:0]    window_length_ff;
   logic [tkw_pkg::ALPHA_W-1:0]  taper_fraction_ff;
   logic                         centering_on_ff;
   logic [tkw_pkg::CENTRE_W-1:0] centre_position_ff;

   logic                         advance;
   logic                         buf_full;
   tkw_pkg::tag_type             front_tag, div_tag, cordic_tag;
   logic [tkw_pkg::LEN_W-1:0]    front_m;
   logic [tkw_pkg::T2_W-1:0]     front_t2;
   logic [tkw_pkg::QUO_W-1:0]    div_phase;
   logic [COEF_FRAC_BITS:0]      cordic_coef;
   logic [COEF_FRAC_BITS+1:0]    rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff    <= 13'd1024;
         window_length_ff   <= 13'd0;
         taper_fraction_ff  <= 17'd32768;
         centering_on_ff    <= 1'b0;
         centre_position_ff <= 14'd512;
      end else if (csr_write_enable) begin
         case (tkw_pkg::csr_index_type'(csr_index))
            tkw_pkg::CSR_TOTAL_LENGTH: begin
               total_length_ff <= csr_write_data[tkw_pkg::LEN_W-1:0];
            end
            tkw_pkg::CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_write_data[tkw_pkg::LEN_W-1:0];
            end
            tkw_pkg::CSR_TAPER_FRACTION: begin
               taper_fraction_ff <= csr_write_data[tkw_pkg::ALPHA_W-1:0];
            end
            tkw_pkg::CSR_CENTERING_ON: begin
               centering_on_ff <= csr_write_data[0];
            end
            tkw_pkg::CSR_CENTRE_POSITION: begin
               centre_position_ff <= csr_write_data[tkw_pkg::CENTRE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance   = !buf_full;
   assign req_ready = advance;

   tkw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (req_valid),
      .sample_index    (req_sample_index),
      .total_length    (total_length_ff),
      .window_length   (window_length_ff),
      .taper_fraction  (taper_fraction_ff),
      .centering_on    (centering_on_ff),
      .centre_position (centre_position_ff),
      .out_tag         (front_tag),
      .out_m           (front_m),
      .out_t2          (front_t2)
   );

   tkw_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_tag    (front_tag),
      .in_m      (front_m),
      .in_t2     (front_t2),
      .out_tag   (div_tag),
      .out_phase (div_phase)
   );

   tkw_cordic #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_cordic (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_tag          (div_tag),
      .in_phase        (div_phase),
      .out_tag         (cordic_tag),
      .out_coefficient (cordic_coef)
   );

   tkw_out_buf #(
      .DATA_W (COEF_FRAC_BITS + 2)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cordic_tag.valid),
      .in_data   ({cordic_tag.in_window, cordic_coef}),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_coefficient   = rsp_data[COEF_FRAC_BITS:0];
   assign rsp_inside_window = rsp_data[COEF_FRAC_BITS+1];

endmodule

[verif/tukey_window_coefficient_tb.sv]
// Self-checking testbench for the Tukey window coefficient generator.
// Depends on tkw_pkg and tukey_window_coefficient; predicts every response and compares it.
`timescale 1ns / 1ps

module tukey_window_coefficient_tb;

   typedef struct {
      logic [16:0] coefficient;
      logic        in_window;
   } coef_result_type;

   class window_scoreboard;
      logic [12:0] total_length;
      logic [12:0] window_length;
      logic [16:0] taper_fraction;
      logic        centering_on;
      logic [13:0] centre_position;
      coef_result_type expected_q[$];
      int          mismatches;
      int          checked;

      function new();
         total_length = 13'd1024;
         window_length = 13'd0;
         taper_fraction = 17'd32768;
         centering_on = 1'b0;
         centre_position = 14'd512;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_register(tkw_pkg::csr_index_type idx, logic [16:0] value);
         case (idx)
            tkw_pkg::CSR_TOTAL_LENGTH: total_length = value[12:0];
            tkw_pkg::CSR_WINDOW_LENGTH: window_length = value[12:0];
            tkw_pkg::CSR_TAPER_FRACTION: taper_fraction = value;
            tkw_pkg::CSR_CENTERING_ON: centering_on = value[0];
            tkw_pkg::CSR_CENTRE_POSITION: centre_position = value[13:0];
            default: ;
         endcase
      endfunction

      function longint cosine_q30(longint theta_in);
         longint theta, x, y, z, nx;
         bit     neg;
         theta = theta_in;
         neg = 0;
         if (theta > longint'(tkw_pkg::HALF_PI_Q30)) begin
            theta = longint'(tkw_pkg::PI_Q30) - theta;
            neg = 1;
         end
         x = longint'(tkw_pkg::GAIN_Q30);
         y = 0;
         z = theta;
         for (int k = 0; k < tkw_pkg::CORDIC_STEPS; k++) begin
            if (z >= 0) begin
               nx = x - (y >>> k);
               y = y + (x >>> k);
               z = z - longint'(tkw_pkg::ATAN_Q30[k]);
            end else begin
               nx = x + (y >>> k);
               y = y - (x >>> k);
               z = z + longint'(tkw_pkg::ATAN_Q30[k]);
            end
            x = nx;
         end
         if (x > (64'sd1 <<< 30)) x = 64'sd1 <<< 30;
         if (x < -(64'sd1 <<< 30)) x = -(64'sd1 <<< 30);
         return neg ? -x : x;
      endfunction

      function longint unsigned taper_edge(longint unsigned m, longint unsigned t2);
         longint unsigned xq, theta, q, r;
         longint          c;
         if (t2 == 0) return 64'd65536;
         xq = (m << 48) / t2;
         if (xq >= (64'd1 << 31)) xq = (64'd1 << 31) - 1;
         theta = (xq * longint'(tkw_pkg::PI_Q30)) >> 31;
         c = cosine_q30(longint'(theta));
         q = longint'((64'sd1 <<< 30) - c) >> 1;
         r = (q + (64'd1 << 13)) >> 14;
         if (r > 64'd65536) r = 64'd65536;
         return r;
      endfunction

      function void note_request(logic [11:0] sample_index);
         longint          len, win, idx, shift, j, centre;
         longint unsigned alpha, t2, lo, hi, coef;
         coef_result_type res;
         bit              in_window;
         idx = sample_index;
         len = total_length;
         if (len < 1) len = 1;
         if (len > tkw_pkg::MAX_LENGTH) len = tkw_pkg::MAX_LENGTH;
         win = (window_length != 0) ? longint'(window_length) : len;
         if (win > tkw_pkg::MAX_LENGTH) win = tkw_pkg::MAX_LENGTH;
         alpha = taper_fraction;
         if (alpha > 65536) alpha = 65536;
         centre = longint'($signed(centre_position));
         shift = centering_on ? centre - win / 2 : 0;
         j = idx - shift;
         in_window = (idx < len) && (j >= 0) && (j < win);
         coef = 0;
         if (in_window) begin
            t2 = alpha * longint'(win - 1);
            lo = t2 >> 17;
            hi = ((longint'(win) << 17) - t2) >> 17;
            if (longint'(j) >= hi) coef = taper_edge(win - 1 - j, t2);
            else if (longint'(j) < lo) coef = taper_edge(j, t2);
            else coef = 64'd65536;
         end
         res.coefficient = coef[16:0];
         res.in_window = in_window;
         expected_q.push_back(res);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_response(logic [16:0] coefficient, logic in_window);
         coef_result_type exp_res;
         if (expected_q.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         exp_res = expected_q.pop_front();
         checked++;
         if (coefficient !== exp_res.coefficient)
            report_mismatch($sformatf("coefficient %0d, expected %0d",
                                      coefficient, exp_res.coefficient));
         if (in_window !== exp_res.in_window)
            report_mismatch($sformatf("inside_window %0b, expected %0b",
                                      in_window, exp_res.in_window));
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [tkw_pkg::IDX_W-1:0]     req_sample_index;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [16:0]                   rsp_coefficient;
   logic                          rsp_inside_window;
   logic                          csr_write_enable;
   tkw_pkg::csr_index_type        csr_index;
   logic [tkw_pkg::CSR_W-1:0]     csr_write_data;

   window_scoreboard     board;
   int                   idle_cycles;
   int                   stall_left;
   int                   hold_left;
   bit                   hold_request;
   int                   requests_sent;
   int                   settings_used;

   tukey_window_coefficient uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_index(req_sample_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_coefficient(rsp_coefficient), .rsp_inside_window(rsp_inside_window),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_index = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = tkw_pkg::CSR_TOTAL_LENGTH;
      csr_write_data = '0;
      idle_cycles = 0;
      stall_left = 0;
      hold_left = 0;
      hold_request = 0;
      requests_sent = 0;
      settings_used = 1;
   end

   // Receiver: random stall after each response, plus one long hold when asked.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_coefficient, rsp_inside_window);
            stall_left = $urandom_range(0, 5);
         end
         if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(logic [11:0] sample_index);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_index <= sample_index;
      do @(posedge clock); while (!req_ready);
      board.note_request(sample_index);
      requests_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_register(tkw_pkg::csr_index_type idx, logic [16:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      board.set_register(idx, value);
   endtask

   task automatic load_setting(logic [12:0] tl, logic [12:0] wl, logic [16:0] alpha,
                               logic cen, logic [13:0] pos);
      drain();
      write_register(tkw_pkg::CSR_TOTAL_LENGTH, 17'(tl));
      write_register(tkw_pkg::CSR_WINDOW_LENGTH, 17'(wl));
      write_register(tkw_pkg::CSR_TAPER_FRACTION, alpha);
      write_register(tkw_pkg::CSR_CENTERING_ON, 17'(cen));
      write_register(tkw_pkg::CSR_CENTRE_POSITION, 17'(pos));
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [12:0] pick_length();
      case ($urandom_range(0, 5))
         0, 1, 2: return 13'($urandom_range(1, 64));
         3: return 13'($urandom_range(0, 8191));
         4: return 13'd4096;
         default: return 13'($urandom_range(0, 2));
      endcase
   endfunction

   function automatic logic [16:0] pick_alpha();
      case ($urandom_range(0, 5))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   initial begin
      logic [12:0] tl, wl;
      int          span;
      int          directed_idx [12];
      directed_idx = '{0, 1, 255, 256, 511, 512, 767, 768, 1022, 1023, 1024, 4095};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_idx[i]) send_request(12'(directed_idx[i]));
      load_setting(13'd8191, 13'd8191, 17'd131071, 1'b1, 14'h3000);
      send_request(12'd0);
      send_request(12'd4095);
      load_setting(13'd0, 13'd0, 17'd0, 1'b0, 14'd0);
      send_request(12'd0);
      send_request(12'd1);
      load_setting(13'd4096, 13'd1, 17'd65536, 1'b1, 14'h1FFF);
      send_request(12'd4095);
      load_setting(13'd4096, 13'd2, 17'd65536, 1'b0, 14'd0);
      send_request(12'd0);
      send_request(12'd1);
      send_request(12'd2);
      load_setting(13'd4096, 13'd4096, 17'd0, 1'b0, 14'd0);
      send_request(12'd0);
      send_request(12'd4095);

      for (int phase = 0; phase < 14; phase++) begin
         tl = pick_length();
         wl = ($urandom_range(0, 3) == 0) ? 13'd0 : pick_length();
         load_setting(tl, wl, pick_alpha(), 1'($urandom_range(0, 1)),
                      14'($urandom_range(0, 16383)));
         span = (tl == 0) ? 1 : (tl > 4096 ? 4096 : int'(tl));
         for (int n = 0; n < 100; n++) begin
            if (phase == 5 && n == 10) hold_request = 1;
            if ($urandom_range(0, 9) < 7) send_request(12'($urandom_range(0, span - 1)));
            else send_request(12'($urandom_range(0, 4095)));
         end
      end

      drain();
      $display("Covered %0d requests over %0d register settings, %0d responses checked.",
               requests_sent, settings_used, board.checked);
      if (board.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tkw_pkg.sv
rtl/core/tkw_front.sv
rtl/core/tkw_divider.sv
rtl/core/tkw_cordic.sv
rtl/core/tkw_out_buf.sv
rtl/core/tukey_window_coefficient.sv
verif/tukey_window_coefficient_tb.sv
